### hdl/canonical_huffman_codec_unit_macros.svh
// Assertion macros for the canonical Huffman codec unit.
// Both macros sample on clk and are disabled while rst is high.
`ifndef CANONICAL_HUFFMAN_CODEC_UNIT_MACROS_SVH
`define CANONICAL_HUFFMAN_CODEC_UNIT_MACROS_SVH
`define CHC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("chc assertion failed");
`define CHC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("chc assertion failed");
`endif

### hdl/chc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Canonical Huffman codec package
// Shared types, codes and default sizes of the codec unit.
// ----------------------------------------------------------------------------
package chc_pkg;
  localparam int SYMBOL_COUNT_DEF = 256;
  localparam int MAX_CODE_LEN_DEF = 32;

  typedef enum logic [1:0] {OP_LOAD, OP_BUILD, OP_ENCODE, OP_DECODE} op_t;
  typedef enum logic [1:0] {KIND_BUILD_DONE, KIND_ENCODED, KIND_DECODED, KIND_ERROR} kind_t;
  typedef enum logic [1:0] {ST_IDLE, ST_ENCODE, ST_SCAN, ST_FINISH} state_t;

  typedef struct packed {
    op_t opcode;
    logic [7:0] symbol;
    logic [5:0] length_in;
    logic bit_in;
  } in_item_t;

  typedef struct packed {
    kind_t result_kind;
    logic [7:0] symbol_out;
    logic [31:0] code_out;
    logic [5:0] length_out;
  } out_item_t;

  typedef struct packed {
    logic [7:0] rd_addr;
    logic [7:0] wr_addr;
    logic len_we;
    logic [5:0] len_wdata;
    logic code_we;
    logic [31:0] code_wdata;
  } mem_req_t;

  typedef struct packed {
    logic [5:0] len;
    logic [31:0] code;
  } mem_rsp_t;
endpackage

### hdl/chc_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Codec channel interfaces
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface chc_in_if;
  logic valid;
  logic ready;
  chc_pkg::in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface chc_out_if;
  logic valid;
  logic ready;
  chc_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### hdl/chc_table_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Codec table memories
// Length and code memories with registered reads; length entries carry
// valid bits so that unwritten symbols read as absent.
// ----------------------------------------------------------------------------
module chc_table_mem #(
  parameter int SYMBOL_COUNT = chc_pkg::SYMBOL_COUNT_DEF
) (
  input logic clk,
  input logic rst,
  input chc_pkg::mem_req_t req,
  output chc_pkg::mem_rsp_t rsp
);
  localparam int SYM_W = $clog2(SYMBOL_COUNT);

  logic [5:0] len_mem [SYMBOL_COUNT];
  logic [31:0] code_mem [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] len_valid;
  logic [SYM_W-1:0] ra;
  logic [SYM_W-1:0] wa;

  assign ra = req.rd_addr[SYM_W-1:0];
  assign wa = req.wr_addr[SYM_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      len_valid <= '0;
    end else if (req.len_we) begin
      len_valid[wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.len_we) begin
      len_mem[wa] <= req.len_wdata;
    end
    if (req.code_we) begin
      code_mem[wa] <= req.code_wdata;
    end
    rsp.len <= len_valid[ra] ? len_mem[ra] : 6'd0;
    rsp.code <= code_mem[ra];
  end
endmodule

### hdl/chc_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Codec sequencer
// Runs load, encode, build and decode items against the table memories.
// Build and decode sweep the length memory one entry per cycle.
// ----------------------------------------------------------------------------
module chc_engine #(
  parameter int SYMBOL_COUNT = chc_pkg::SYMBOL_COUNT_DEF,
  parameter int MAX_CODE_LEN = chc_pkg::MAX_CODE_LEN_DEF
) (
  input logic clk,
  input logic rst,
  input logic in_valid,
  output logic in_ready,
  input chc_pkg::in_item_t in_item,
  output logic res_valid,
  input logic res_ready,
  output chc_pkg::out_item_t res,
  output chc_pkg::mem_req_t mreq,
  input chc_pkg::mem_rsp_t mrsp
);
  localparam int SYM_W = $clog2(SYMBOL_COUNT);
  localparam int LEN_CAP = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;
  localparam logic [5:0] CAP = 6'(LEN_CAP);
  localparam logic [SYM_W:0] SC = (SYM_W + 1)'(SYMBOL_COUNT);
  localparam logic [SYM_W-1:0] LAST = SYM_W'(SYMBOL_COUNT - 1);

  chc_pkg::state_t state, state_next;
  logic is_build, is_build_next;
  logic [SYM_W:0] issue, issue_next;
  logic pv, pv_next;
  logic [SYM_W-1:0] pidx, pidx_next;
  logic [5:0] cur_len, cur_len_next;
  logic [5:0] prev, prev_next;
  logic [31:0] value, value_next;
  logic [31:0] acc, acc_next;
  logic [5:0] cnt, cnt_next;
  chc_pkg::out_item_t res_next;
  logic sym_ok;
  logic last;
  logic [31:0] shifted;
  logic [31:0] mask;

  assign sym_ok = {1'b0, in_item.symbol} < 9'(SYMBOL_COUNT);
  assign last = pv && (pidx == LAST);
  assign shifted = (prev != 6'd0 && cur_len != prev) ? (value << (cur_len - prev)) : value;
  assign mask = 32'((33'd1 << cur_len) - 33'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= chc_pkg::ST_IDLE;
      acc <= '0;
      cnt <= '0;
      pv <= 1'b0;
    end else begin
      state <= state_next;
      acc <= acc_next;
      cnt <= cnt_next;
      pv <= pv_next;
    end
  end

  always_ff @(posedge clk) begin
    is_build <= is_build_next;
    issue <= issue_next;
    pidx <= pidx_next;
    cur_len <= cur_len_next;
    prev <= prev_next;
    value <= value_next;
    res <= res_next;
  end

  always_comb begin
    state_next = state;
    is_build_next = is_build;
    issue_next = issue;
    pv_next = pv;
    pidx_next = pidx;
    cur_len_next = cur_len;
    prev_next = prev;
    value_next = value;
    acc_next = acc;
    cnt_next = cnt;
    res_next = res;
    mreq = '0;
    in_ready = 1'b0;
    res_valid = 1'b0;
    case (state)
      chc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_item.opcode)
            chc_pkg::OP_LOAD: begin
              if (sym_ok) begin
                mreq.len_we = 1'b1;
                mreq.wr_addr = in_item.symbol;
                mreq.len_wdata = (in_item.length_in > CAP) ? CAP : in_item.length_in;
              end
            end
            chc_pkg::OP_BUILD: begin
              is_build_next = 1'b1;
              issue_next = '0;
              pv_next = 1'b0;
              cur_len_next = 6'd1;
              prev_next = '0;
              value_next = '0;
              acc_next = '0;
              cnt_next = '0;
              state_next = chc_pkg::ST_SCAN;
            end
            chc_pkg::OP_ENCODE: begin
              res_next = '{chc_pkg::KIND_ERROR, in_item.symbol, 32'd0, 6'd0};
              if (sym_ok) begin
                mreq.rd_addr = in_item.symbol;
                state_next = chc_pkg::ST_ENCODE;
              end else begin
                state_next = chc_pkg::ST_FINISH;
              end
            end
            default: begin
              acc_next = {acc[30:0], in_item.bit_in};
              cnt_next = cnt + 6'd1;
              is_build_next = 1'b0;
              issue_next = '0;
              pv_next = 1'b0;
              state_next = chc_pkg::ST_SCAN;
            end
          endcase
        end
      end
      chc_pkg::ST_ENCODE: begin
        if (mrsp.len != 6'd0) begin
          res_next = '{chc_pkg::KIND_ENCODED, res.symbol_out, mrsp.code, mrsp.len};
        end
        state_next = chc_pkg::ST_FINISH;
      end
      chc_pkg::ST_SCAN: begin
        if (issue < SC) begin
          mreq.rd_addr = 8'(issue[SYM_W-1:0]);
          issue_next = issue + 1'b1;
          pv_next = 1'b1;
          pidx_next = issue[SYM_W-1:0];
        end else begin
          pv_next = 1'b0;
        end
        if (pv && is_build) begin
          if (mrsp.len == cur_len) begin
            mreq.code_we = 1'b1;
            mreq.wr_addr = 8'(pidx);
            mreq.code_wdata = shifted & mask;
            value_next = shifted + 32'd1;
            prev_next = cur_len;
          end
          if (last) begin
            if (cur_len >= CAP) begin
              res_next = '{chc_pkg::KIND_BUILD_DONE, 8'd0, 32'd0, 6'd0};
              state_next = chc_pkg::ST_FINISH;
            end else begin
              cur_len_next = cur_len + 6'd1;
              issue_next = '0;
              pv_next = 1'b0;
            end
          end
        end else if (pv) begin
          if (mrsp.len == cnt && mrsp.code == acc) begin
            res_next = '{chc_pkg::KIND_DECODED, 8'(pidx), acc, cnt};
            acc_next = '0;
            cnt_next = '0;
            state_next = chc_pkg::ST_FINISH;
          end else if (last) begin
            if (cnt >= CAP) begin
              res_next = '{chc_pkg::KIND_ERROR, 8'd0, 32'd0, 6'd0};
              acc_next = '0;
              cnt_next = '0;
              state_next = chc_pkg::ST_FINISH;
            end else begin
              state_next = chc_pkg::ST_IDLE;
            end
          end
        end
      end
      default: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = chc_pkg::ST_IDLE;
        end
      end
    endcase
  end
endmodule

### hdl/canonical_huffman_codec_unit.sv
`timescale 1ns / 1ps
// Load gives no result. Encode reads the length and code and passes the result to the output register.
// Decode sweeps the length memory for each input bit.
// Build sweeps the length memory once per code length, up to min(MAX_CODE_LEN, 32).
// One item is in work at a time; the output register frees the sequencer.
// Reset clears the length valid bits and decoder state at once; no clearing pass.
// ----------------------------------------------------------------------------
// Canonical Huffman codec unit
// Top level: sequencer, table memories and output register.
// ----------------------------------------------------------------------------
`include "canonical_huffman_codec_unit_macros.svh"
module canonical_huffman_codec_unit #(
  parameter int SYMBOL_COUNT = chc_pkg::SYMBOL_COUNT_DEF,
  parameter int MAX_CODE_LEN = chc_pkg::MAX_CODE_LEN_DEF
) (
  input logic clk,
  input logic rst,
  chc_in_if.sink in_item,
  chc_out_if.source out_item
);
  chc_pkg::mem_req_t mreq;
  chc_pkg::mem_rsp_t mrsp;
  chc_pkg::out_item_t res;
  logic res_valid;
  logic res_ready;
  logic out_valid;

  chc_table_mem #(.SYMBOL_COUNT(SYMBOL_COUNT)) u_mem (
    .clk(clk), .rst(rst), .req(mreq), .rsp(mrsp)
  );

  chc_engine #(.SYMBOL_COUNT(SYMBOL_COUNT), .MAX_CODE_LEN(MAX_CODE_LEN)) u_engine (
    .clk(clk), .rst(rst),
    .in_valid(in_item.valid), .in_ready(in_item.ready), .in_item(in_item.payload),
    .res_valid(res_valid), .res_ready(res_ready), .res(res),
    .mreq(mreq), .mrsp(mrsp)
  );

  assign res_ready = !out_valid || out_item.ready;
  assign out_item.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_item.payload <= res;
    end
  end

  `CHC_ASSERT_IMPL(a_decoded_len, out_valid && out_item.payload.result_kind == chc_pkg::KIND_DECODED, out_item.payload.length_out != 6'd0)
  `CHC_ASSERT_IMPL(a_encoded_len, out_valid && out_item.payload.result_kind == chc_pkg::KIND_ENCODED, out_item.payload.length_out != 6'd0)
  `CHC_ASSERT_NEXT(a_build_busy, in_item.valid && in_item.ready && in_item.payload.opcode == chc_pkg::OP_BUILD, !in_item.ready)
endmodule
